// File: sv/i2cbe_pkg.sv
// shared commands, constants and item types of the i2c master bit engine
package i2cbe_pkg;

  // command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  // start status codes
  localparam logic [1:0] START_OK    = 2'd0;
  localparam logic [1:0] START_BUSY  = 2'd1;
  localparam logic [1:0] START_ERROR = 2'd2;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;
  localparam logic [7:0] MSB_MASK          = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

  // classified tick request
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       sda_line;
  } item_t;

endpackage

// File: sv/i2cbe_if.sv
// handshake channels of the i2c master bit engine
interface i2cbe_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       sda_line;

  modport source (output valid, output command, output data_byte, output sda_line,
                  input ready);
  modport sink   (input valid, input command, input data_byte, input sda_line,
                  output ready);
endinterface

interface i2cbe_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_driving;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       nack_sticky;
  logic [1:0] start_status;

  modport source (output valid, output scl_level, output sda_level, output sda_driving,
                  output busy_res, output done_res, output read_data, output nack_sticky,
                  output start_status, input ready);
  modport sink   (input valid, input scl_level, input sda_level, input sda_driving,
                  input busy_res, input done_res, input read_data, input nack_sticky,
                  input start_status, output ready);
endinterface

interface i2cbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] phase_ticks;

  modport source (output valid, output phase_ticks, input ready);
  modport sink   (input valid, input phase_ticks, output ready);
endinterface

// File: sv/i2cbe_front.sv
// front end: accepts tick requests and classifies the command
module i2cbe_front (
  i2cbe_cmd_if.sink          cmd_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output i2cbe_pkg::item_t   push_item_o
);
  import i2cbe_pkg::*;

  logic is_cmd;

  // unknown codes run as a plain tick
  assign is_cmd = (cmd_i.command >= CMD_START) && (cmd_i.command <= CMD_READ_NACK);

  assign cmd_i.ready  = push_ready_i;
  assign push_valid_o = cmd_i.valid;

  // only a write carries its byte into the shifter
  always_comb begin
    push_item_o.command   = is_cmd ? cmd_i.command : CMD_TICK;
    push_item_o.data_byte = (cmd_i.command == CMD_WRITE) ? cmd_i.data_byte : 8'd0;
    push_item_o.sda_line  = cmd_i.sda_line;
  end

endmodule

// File: sv/i2cbe_queue.sv
// two-entry queue between the front end and the bus sequencer
module i2cbe_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  i2cbe_pkg::item_t   push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output i2cbe_pkg::item_t   pop_item_o
);
  import i2cbe_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: sv/i2cbe_back.sv
// back end: bus sequencer that advances one tick per request and registers the result
module i2cbe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cbe_cfg_if.sink          cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  i2cbe_pkg::item_t   pop_item_i,
  i2cbe_res_if.source        res_o
);
  import i2cbe_pkg::*;

  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_1    = 3'd1;
  localparam logic [2:0] STEP_2    = 3'd2;
  localparam logic [2:0] STEP_3    = 3'd3;
  localparam logic [2:0] STEP_4    = 3'd4;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       en;
    logic [7:0] shift;
  } lines_t;

  // levels set when a step begins
  function automatic lines_t enter_step(input logic [2:0] cmd, input logic [2:0] step,
                                        input logic [3:0] bc, input lines_t cur);
    lines_t r;
    r = cur;
    case (cmd)
      CMD_START: begin
        if (step == STEP_1) begin
          r.en = 1'b1; r.sda = 1'b1; r.scl = 1'b1;
        end else begin
          r.sda = 1'b0;
        end
      end
      CMD_STOP: begin
        if (step == STEP_1) begin
          r.en = 1'b1; r.scl = 1'b0;
        end else if (step == STEP_2) begin
          r.sda = 1'b0;
        end else if (step == STEP_3) begin
          r.scl = 1'b1;
        end else begin
          r.sda = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (bc < BITS_PER_BYTE) begin
          if (step == STEP_1) begin
            r.en = 1'b1; r.scl = 1'b0;
          end else if (step == STEP_2) begin
            r.sda   = |(cur.shift & MSB_MASK);
            r.shift = {cur.shift[6:0], 1'b0};
          end else begin
            r.scl = 1'b1;
          end
        end else begin
          if (step == STEP_1) begin
            r.en = 1'b0; r.scl = 1'b0;
          end else if (step == STEP_2) begin
            r.sda = 1'b1;
          end else begin
            r.scl = 1'b1;
          end
        end
      end
      default: begin
        if (bc < BITS_PER_BYTE) begin
          if (step == STEP_1) begin
            r.en = 1'b0;
            if (bc == 4'd0) r.sda = 1'b1;
            r.scl = 1'b0;
          end else begin
            r.scl = 1'b1;
          end
        end else begin
          if (step == STEP_1) begin
            r.en = 1'b1; r.scl = 1'b0;
          end else if (step == STEP_2) begin
            r.sda = (cmd == CMD_READ_NACK);
          end else if (step == STEP_3) begin
            r.scl = 1'b1;
          end else begin
            r.scl = 1'b0;
          end
        end
      end
    endcase
    return r;
  endfunction

  logic [7:0] phase_ticks_q;
  logic [2:0] step_q, step_d;
  logic [3:0] bc_q, bc_d;
  logic [7:0] tick_q, tick_d;
  lines_t     lines_q, lines_d;
  logic       nack_q, nack_d;
  logic [1:0] start_res_q, start_res_d;
  logic [2:0] pend_q, pend_d;
  logic [7:0] rx_q, rx_d;
  logic       scl_now, sda_now, en_now, busy, done;
  logic       pop;

  logic       out_valid_q;
  logic       out_scl_q, out_sda_q, out_en_q, out_busy_q, out_done_q, out_nack_q;
  logic [7:0] out_rx_q;
  logic [1:0] out_start_q;

  assign pop_ready_o = !out_valid_q || res_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign cfg_i.ready = 1'b1;

  // one bus tick
  always_comb begin
    step_d      = step_q;
    bc_d        = bc_q;
    tick_d      = tick_q;
    lines_d     = lines_q;
    nack_d      = nack_q;
    start_res_d = start_res_q;
    pend_d      = pend_q;
    rx_d        = rx_q;
    busy        = 1'b0;
    done        = 1'b0;

    // command launch from idle
    if (step_q == STEP_IDLE && pop_item_i.command != CMD_TICK) begin
      pend_d        = pop_item_i.command;
      bc_d          = 4'd0;
      lines_d.shift = pop_item_i.data_byte;
      if (pop_item_i.command == CMD_START) nack_d = 1'b0;
      lines_d = enter_step(pend_d, STEP_1, bc_d, lines_d);
      step_d  = STEP_1;
      tick_d  = 8'd0;
    end

    scl_now = lines_d.scl;
    sda_now = lines_d.sda;
    en_now  = lines_d.en;

    // phase timing and end of step
    if (step_d != STEP_IDLE) begin
      busy = 1'b1;
      if (({1'b0, tick_d} + 9'd1) >= {1'b0, phase_ticks_q}) begin
        case (pend_d)
          CMD_START: begin
            if (step_d == STEP_1 && !pop_item_i.sda_line) begin
              start_res_d = START_BUSY; done = 1'b1;
            end else if (step_d == STEP_2 && pop_item_i.sda_line) begin
              start_res_d = START_ERROR; done = 1'b1;
            end else if (step_d == STEP_3) begin
              start_res_d = START_OK; done = 1'b1;
            end else begin
              step_d  = step_d + 3'd1;
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end
          end
          CMD_STOP: begin
            if (step_d >= STEP_4) begin
              done = 1'b1;
            end else begin
              step_d  = step_d + 3'd1;
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end
          end
          CMD_WRITE: begin
            if (bc_d < BITS_PER_BYTE) begin
              if (step_d >= STEP_3) begin
                bc_d   = bc_d + 4'd1;
                step_d = STEP_1;
              end else begin
                step_d = step_d + 3'd1;
              end
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end else if (step_d >= STEP_3) begin
              // acknowledge sampled while scl is high
              if (pop_item_i.sda_line) nack_d = 1'b1;
              lines_d.scl = 1'b0;
              done        = 1'b1;
            end else begin
              step_d  = step_d + 3'd1;
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end
          end
          default: begin
            if (bc_d < BITS_PER_BYTE) begin
              if (step_d >= STEP_2) begin
                lines_d.shift = {lines_d.shift[6:0], pop_item_i.sda_line};
                bc_d          = bc_d + 4'd1;
                if (bc_d >= BITS_PER_BYTE) rx_d = lines_d.shift;
                step_d = STEP_1;
              end else begin
                step_d = step_d + 3'd1;
              end
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end else if (step_d >= STEP_4) begin
              done = 1'b1;
            end else begin
              step_d  = step_d + 3'd1;
              tick_d  = 8'd0;
              lines_d = enter_step(pend_d, step_d, bc_d, lines_d);
            end
          end
        endcase
        if (done) begin
          step_d = STEP_IDLE;
          tick_d = 8'd0;
        end
      end else begin
        tick_d = tick_d + 8'd1;
      end
    end
  end

  // sequencer state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RESET;
      step_q        <= STEP_IDLE;
      bc_q          <= 4'd0;
      tick_q        <= 8'd0;
      lines_q       <= '{scl: 1'b1, sda: 1'b1, en: 1'b1, shift: 8'd0};
      nack_q        <= 1'b0;
      start_res_q   <= START_OK;
      pend_q        <= CMD_TICK;
      rx_q          <= 8'd0;
    end else begin
      if (cfg_i.valid) begin
        phase_ticks_q <= cfg_i.phase_ticks;
      end
      if (pop) begin
        step_q      <= step_d;
        bc_q        <= bc_d;
        tick_q      <= tick_d;
        lines_q     <= lines_d;
        nack_q      <= nack_d;
        start_res_q <= start_res_d;
        pend_q      <= pend_d;
        rx_q        <= rx_d;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop_valid_i;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_scl_q   <= scl_now;
      out_sda_q   <= sda_now;
      out_en_q    <= en_now;
      out_busy_q  <= busy;
      out_done_q  <= done;
      out_rx_q    <= rx_d;
      out_nack_q  <= nack_d;
      out_start_q <= start_res_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.scl_level    = out_scl_q;
  assign res_o.sda_level    = out_sda_q;
  assign res_o.sda_driving  = out_en_q;
  assign res_o.busy_res     = out_busy_q;
  assign res_o.done_res     = out_done_q;
  assign res_o.read_data    = out_rx_q;
  assign res_o.nack_sticky  = out_nack_q;
  assign res_o.start_status = out_start_q;

endmodule

// File: sv/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: front end, request queue, bus sequencer
//
// Every request on cmd_i is one timing tick of the bus: it carries a command
// (tick only, start, stop, write byte, read with ack, read with nack), the byte
// for a write and the sda level seen during the tick. Commands are taken only
// while the sequencer is idle; a command arriving mid-sequence runs as a tick.
// Each request yields exactly one request on res_o with the scl/sda levels for
// that tick, busy/done flags, the last received byte, the sticky ack error and
// the last start status. cfg_i writes phase_ticks, the length of each bus phase.
// Throughput is one request per cycle while res_o is ready; a taken request is
// held in the two-entry queue and its result then in the sequencer's output
// register. When res_o stalls the output register holds and the queue fills,
// then cmd_i.ready drops; cmd_i.ready depends only on the queue fill level.
// Reset clears the queue and puts the sequencer idle with scl high, sda
// high and driven, phase_ticks 10 and all status cleared.
module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cbe_cfg_if.sink   cfg_i,
  i2cbe_cmd_if.sink   cmd_i,
  i2cbe_res_if.source res_o
);
  import i2cbe_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  // request classification
  i2cbe_front u_front (
    .cmd_i        (cmd_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // decoupling queue
  i2cbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // bus sequencer
  i2cbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_o       (res_o)
  );

endmodule
